>>> hw/rtl/hgkg_pkg.sv
// Shared constants and types for the Hessian-of-Gaussian kernel sample generator.
// Used by hgkg_exp and hessian_gaussian_kernel_gen; depends on nothing else.
`default_nettype none

package hgkg_pkg;

	// Hessian component selector codes
	localparam logic [2:0] COMP_XX = 3'd0;
	localparam logic [2:0] COMP_YY = 3'd1;
	localparam logic [2:0] COMP_ZZ = 3'd2;
	localparam logic [2:0] COMP_XY = 3'd3;
	localparam logic [2:0] COMP_ZX = 3'd4;
	localparam logic [2:0] COMP_ZY = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_SIZE_X      = 3'd0;
	localparam logic [2:0] REG_SIZE_Y      = 3'd1;
	localparam logic [2:0] REG_SIZE_Z      = 3'd2;
	localparam logic [2:0] REG_COMPONENT   = 3'd3;
	localparam logic [2:0] REG_INV_SIG_SQ  = 3'd4;
	localparam logic [2:0] REG_INV_2SIG_SQ = 3'd5;
	localparam logic [2:0] REG_SCALE_DIAG  = 3'd6;
	localparam logic [2:0] REG_SCALE_CROSS = 3'd7;

	localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;
	localparam logic [26:0] LOG2E_Q26 = 27'd96817625;

	localparam int POLY_TERMS = 10;
	// range check, 2^int split, x = f*ln2, three stages per Horner step, final shift
	localparam int EXP_LAT    = 4 + 3 * POLY_TERMS;

	localparam int MAG_W = 54;

	// exponent path control that rides along the Horner stages
	typedef struct packed {
		logic       zero;
		logic [5:0] n;
	} exp_tag_t;

	// fold a 1-based index into wrap-around order, doubled: 2*(i - 0.5) or 2*(i - s - 0.5)
	function automatic logic signed [13:0] fold_coord(input logic [10:0] idx,
		input logic [10:0] s);
		logic [10:0]        half;
		logic signed [13:0] diff;
		logic signed [13:0] d;
		half = s >> 1;
		diff = $signed({3'b000, idx}) - $signed({3'b000, s});
		if (idx <= half) begin
			d = $signed({2'b00, idx, 1'b0}) - 14'sd1;
		end else begin
			d = (diff <<< 1) - 14'sd1;
		end
		return d;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hessian_gaussian_kernel_gen.sv
// Hessian-of-Gaussian 3D kernel sample generator: one index in, one Q8.24 sample out.
// Top level; uses hgkg_pkg and hgkg_exp.
//
// Takes one transaction per cycle unless stalled and returns one sample per transaction,
// in order (4 fold/square stages, 34 in the exp unit, 3 scale/saturate stages).
// The whole pipeline advances as one; it stalls only while the output register
// holds a sample that is not taken, and it keeps taking input while that register is
// empty. Write configuration only when the pipeline holds nothing; cfg_ready is
// always high.
`default_nettype none

module hessian_gaussian_kernel_gen #(
	parameter int MAX_DIM   = 1024,
	parameter int FRAC_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // index_x[10:0], index_y[21:11], index_z[32:22], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // kernel_value[31:0]
	output logic      [0:0]  m_tuser,   // saturated[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int          LAT  = hgkg_pkg::EXP_LAT;
	localparam int          MW   = hgkg_pkg::MAG_W;
	localparam logic [12:0] MAXD = 13'(MAX_DIM);
	localparam logic [MW-1:0] ONE_F = MW'(1) << FRAC_BITS;

	logic [10:0] size_x_q, size_y_q, size_z_q;
	logic [2:0]  comp_q;
	logic [31:0] inv_sig_q, inv_2sig_q, scale_diag_q, scale_cross_q;

	logic ce;
	logic is_diag, is_cross;

	logic [10:0] sx_c, sy_c, sz_c;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [13:0]       dx_s1, dy_s1, dz_s1;
	logic signed [27:0]       sqx, sqy, sqz, pr;
	logic [23:0]              sqx_s2, sqy_s2, sqz_s2, dsq_s2;
	logic signed [27:0]       pr_s2;
	logic [25:0]              sum2_s3;
	logic [55:0]              qprod_s3;
	logic [23:0]              ap_s3;
	logic                     prpos_s3;
	logic [57:0]              tprod;
	logic [55:0]              t_s4;
	logic [MW-1:0]            mag_s4;
	logic                     neg_s4;
	logic [MW-1:0]            q_diag;

	logic [30:0]              e_exp;
	logic                     vd_s   [LAT];
	logic [MW-1:0]            magd_s [LAT];
	logic                     negd_s [LAT];

	logic [31:0]              scale;
	logic [62:0]              mprod;
	logic [31:0]              m_s5;
	logic [MW-1:0]            mag_s5;
	logic                     neg_s5;
	logic [53:0]              hi_s6;
	logic [63:0]              lo_s6;
	logic                     neg_s6;
	logic [56:0]              res;

	assign cfg_ready = 1'b1;
	assign ce        = !m_tvalid || m_tready;
	assign s_tready  = ce;

	assign is_diag  = (comp_q <= hgkg_pkg::COMP_ZZ);
	assign is_cross = (comp_q >= hgkg_pkg::COMP_XY) && (comp_q <= hgkg_pkg::COMP_ZY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q      <= 11'd256;
			size_y_q      <= 11'd256;
			size_z_q      <= 11'd256;
			comp_q        <= hgkg_pkg::COMP_XX;
			inv_sig_q     <= 32'd16777216;
			inv_2sig_q    <= 32'd8388608;
			scale_diag_q  <= 32'd1073741824;
			scale_cross_q <= 32'd1073741824;
		end else if (cfg_valid) begin
			case (cfg_index)
				hgkg_pkg::REG_SIZE_X:      size_x_q      <= cfg_data[10:0];
				hgkg_pkg::REG_SIZE_Y:      size_y_q      <= cfg_data[10:0];
				hgkg_pkg::REG_SIZE_Z:      size_z_q      <= cfg_data[10:0];
				hgkg_pkg::REG_COMPONENT:   comp_q        <= cfg_data[2:0];
				hgkg_pkg::REG_INV_SIG_SQ:  inv_sig_q     <= cfg_data;
				hgkg_pkg::REG_INV_2SIG_SQ: inv_2sig_q    <= cfg_data;
				hgkg_pkg::REG_SCALE_DIAG:  scale_diag_q  <= cfg_data;
				hgkg_pkg::REG_SCALE_CROSS: scale_cross_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes above MAX_DIM behave as MAX_DIM
	assign sx_c = ({2'b00, size_x_q} > MAXD) ? MAXD[10:0] : size_x_q;
	assign sy_c = ({2'b00, size_y_q} > MAXD) ? MAXD[10:0] : size_y_q;
	assign sz_c = ({2'b00, size_z_q} > MAXD) ? MAXD[10:0] : size_z_q;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < LAT; i++) vd_s[i] <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vd_s[0] <= v_s4;
			for (int i = 1; i < LAT; i++) vd_s[i] <= vd_s[i-1];
			v_s5     <= vd_s[LAT-1];
			v_s6     <= v_s5;
			m_tvalid <= v_s6;
		end
	end

	// stage 1: fold indexes
	always_ff @(posedge clk) begin
		if (ce) begin
			dx_s1 <= hgkg_pkg::fold_coord(s_tdata[10:0], sx_c);
			dy_s1 <= hgkg_pkg::fold_coord(s_tdata[21:11], sy_c);
			dz_s1 <= hgkg_pkg::fold_coord(s_tdata[32:22], sz_c);
		end
	end

	// stage 2: squares and the cross product
	always_comb begin
		sqx = dx_s1 * dx_s1;
		sqy = dy_s1 * dy_s1;
		sqz = dz_s1 * dz_s1;
		case (comp_q)
			hgkg_pkg::COMP_XY: pr = dx_s1 * dy_s1;
			hgkg_pkg::COMP_ZX: pr = dz_s1 * dx_s1;
			hgkg_pkg::COMP_ZY: pr = dz_s1 * dy_s1;
			default:           pr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sqx_s2 <= sqx[23:0];
			sqy_s2 <= sqy[23:0];
			sqz_s2 <= sqz[23:0];
			pr_s2  <= pr;
			case (comp_q)
				hgkg_pkg::COMP_YY: dsq_s2 <= sqy[23:0];
				hgkg_pkg::COMP_ZZ: dsq_s2 <= sqz[23:0];
				default:           dsq_s2 <= sqx[23:0];
			endcase
		end
	end

	// stage 3: r^2 and d^2/sigma^2 product
	always_ff @(posedge clk) begin
		if (ce) begin
			sum2_s3  <= 26'(sqx_s2) + 26'(sqy_s2) + 26'(sqz_s2);
			qprod_s3 <= 56'(dsq_s2) * 56'(inv_sig_q);
			ap_s3    <= pr_s2[27] ? 24'(-pr_s2) : pr_s2[23:0];
			prpos_s3 <= !pr_s2[27] && (pr_s2 != '0);
		end
	end

	// stage 4: exponent argument and polynomial magnitude
	assign tprod  = 58'(sum2_s3) * 58'(inv_2sig_q);
	assign q_diag = qprod_s3[55:2];

	always_ff @(posedge clk) begin
		if (ce) begin
			t_s4 <= tprod[57:2];
			if (is_diag) begin
				neg_s4 <= (q_diag >= ONE_F);
				mag_s4 <= (q_diag >= ONE_F) ? q_diag - ONE_F : ONE_F - q_diag;
			end else begin
				neg_s4 <= prpos_s3;
				mag_s4 <= MW'(ap_s3) << (FRAC_BITS - 2);
			end
		end
	end

	hgkg_exp #(
		.FRAC_BITS(FRAC_BITS)
	) u_exp (
		.clk (clk),
		.ce  (ce),
		.t   (t_s4),
		.e   (e_exp)
	);

	// magnitude and sign wait alongside the exp unit
	always_ff @(posedge clk) begin
		if (ce) begin
			magd_s[0] <= mag_s4;
			negd_s[0] <= neg_s4;
			for (int i = 1; i < LAT; i++) begin
				magd_s[i] <= magd_s[i-1];
				negd_s[i] <= negd_s[i-1];
			end
		end
	end

	// stage 5: m = scale * E
	assign scale = is_diag ? scale_diag_q : scale_cross_q;
	assign mprod = 63'(scale) * 63'(e_exp);

	always_ff @(posedge clk) begin
		if (ce) begin
			m_s5   <= mprod[61:30];
			mag_s5 <= magd_s[LAT-1];
			neg_s5 <= negd_s[LAT-1];
		end
	end

	// stage 6: split product, high and low halves of the magnitude
	always_ff @(posedge clk) begin
		if (ce) begin
			hi_s6  <= 54'(mag_s5[53:32]) * 54'(m_s5);
			lo_s6  <= 64'(mag_s5[31:0]) * 64'(m_s5);
			neg_s6 <= neg_s5;
		end
	end

	// stage 7: recombine, apply sign, saturate
	assign res = 57'({hi_s6, 2'b00}) + 57'(lo_s6[63:30]);

	always_ff @(posedge clk) begin
		if (ce) begin
			if (!is_diag && !is_cross) begin
				m_tdata <= '0;
				m_tuser <= 1'b0;
			end else if (neg_s6) begin
				if (res > 57'h0_8000_0000) begin
					m_tdata <= 32'h8000_0000;
					m_tuser <= 1'b1;
				end else begin
					m_tdata <= 32'(57'd0 - res);
					m_tuser <= 1'b0;
				end
			end else begin
				if (res > 57'h0_7FFF_FFFF) begin
					m_tdata <= 32'h7FFF_FFFF;
					m_tuser <= 1'b1;
				end else begin
					m_tdata <= res[31:0];
					m_tuser <= 1'b0;
				end
			end
		end
	end

	a_unused_comp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (comp_q > hgkg_pkg::COMP_ZY)) |-> (m_tdata == '0 && m_tuser == 1'b0))
		else $error("unused component produced a nonzero sample");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
		else $error("saturated flag without a clipped value");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && ce) |=> m_tvalid)
		else $error("sample lost at the output register");

endmodule

`default_nettype wire

>>> hw/rtl/hgkg_exp.sv
// Pipelined exp(-t): t in unsigned Q.FRAC_BITS, result in Q30, 2^-n times a degree-10
// Horner polynomial. Advances on ce. Uses hgkg_pkg.
`default_nettype none

module hgkg_exp #(
	parameter int FRAC_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        ce,
	input  wire logic [55:0] t,
	output logic      [30:0] e
);

	localparam int          TL_W = FRAC_BITS + 5;
	localparam logic [55:0] THR  = 56'(24) << FRAC_BITS;
	localparam int          NT   = hgkg_pkg::POLY_TERMS;

	logic              zero_s1;
	logic [TL_W-1:0]   tl_s1;
	logic              zero_s2;
	logic [5:0]        n_s2;
	logic [29:0]       f_s2;

	logic [TL_W+26:0]  uprod;
	logic [TL_W:0]     u;
	logic [59:0]       xprod;

	logic [29:0]             hx_s  [NT+1];
	hgkg_pkg::exp_tag_t      htag_s[NT+1];
	logic [30:0]             hp_s  [1:NT];

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s1 <= (t >= THR);
			tl_s1   <= t[TL_W-1:0];
		end
	end

	// 2^-u split: n = integer part, f = fraction widened to Q30
	always_comb begin
		uprod = (TL_W+27)'(tl_s1) * (TL_W+27)'(hgkg_pkg::LOG2E_Q26);
		u     = uprod[TL_W+26:26];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s2 <= zero_s1;
			n_s2    <= u[FRAC_BITS+5:FRAC_BITS];
			f_s2    <= 30'(u[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
		end
	end

	assign xprod = 60'(f_s2) * 60'(hgkg_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		if (ce) begin
			hx_s[0]        <= xprod[59:30];
			htag_s[0].zero <= zero_s2;
			htag_s[0].n    <= n_s2;
		end
	end

	// p = ONE - ((x*p) >> 30) / K, K = NT down to 1
	for (genvar g = 0; g < NT; g++) begin : g_horner
		localparam int          K     = NT - g;
		localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

		logic [30:0]        p_in;
		logic [60:0]        prod_sa;
		logic [29:0]        x_sa;
		hgkg_pkg::exp_tag_t tag_sa;
		logic [29:0]        v_sb;
		logic [29:0]        est_sb;
		logic [29:0]        x_sb;
		hgkg_pkg::exp_tag_t tag_sb;
		logic [62:0]        rprod;
		logic [33:0]        rem;
		logic [29:0]        q;

		if (g == 0) begin : g_first
			assign p_in = hgkg_pkg::Q30_ONE;
		end else begin : g_next
			assign p_in = hp_s[g];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				prod_sa <= 61'(hx_s[g]) * 61'(p_in);
				x_sa    <= hx_s[g];
				tag_sa  <= htag_s[g];
			end
		end

		// reciprocal estimate is exact or one low
		assign rprod = 63'(prod_sa[59:30]) * 63'(RECIP);

		always_ff @(posedge clk) begin
			if (ce) begin
				v_sb   <= prod_sa[59:30];
				est_sb <= rprod[61:32];
				x_sb   <= x_sa;
				tag_sb <= tag_sa;
			end
		end

		always_comb begin
			rem = 34'(v_sb) - 34'(est_sb) * 34'(K);
			q   = (rem >= 34'(K)) ? est_sb + 30'd1 : est_sb;
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				hp_s[g+1]   <= hgkg_pkg::Q30_ONE - 31'(q);
				hx_s[g+1]   <= x_sb;
				htag_s[g+1] <= tag_sb;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			e <= htag_s[NT].zero ? 31'd0 : (hp_s[NT] >> htag_s[NT].n);
		end
	end

endmodule

`default_nettype wire
